// ===== rtl/websocket_frame_receiver_top_defines.svh =====
// Assertion macros shared by the frame receiver RTL.
// Include with the bare file name; SYNTH empties every macro body.
`ifndef WEBSOCKET_FRAME_RECEIVER_TOP_DEFINES_SVH
`define WEBSOCKET_FRAME_RECEIVER_TOP_DEFINES_SVH
`ifndef SYNTH
// Check a property at every rising edge outside reset.
`define WFR_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("wfr assertion failed");
// Check a property at every rising edge, reset included.
`define WFR_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("wfr assertion failed");
`else
`define WFR_ASSERT(label, clk, rstn, prop)
`define WFR_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== rtl/wfr_pkg.sv =====
// Shared types and constants of the WebSocket frame receiver.
// No dependencies; imported by every receiver module.
`default_nettype none
package wfr_pkg;

  localparam int unsigned PayloadLengthBitsDef = 31;
  localparam int unsigned QueueDepthDef        = 4;
  localparam int unsigned TdataOutBits         = 16;

  // Frame opcodes
  localparam logic [3:0] OP_CONT     = 4'h0;
  localparam logic [3:0] OP_TEXT     = 4'h1;
  localparam logic [3:0] OP_BINARY   = 4'h2;
  localparam logic [3:0] OP_SHUTDOWN = 4'h8;
  localparam logic [3:0] OP_PING     = 4'h9;
  localparam logic [3:0] OP_PONG     = 4'hA;

  // Seven-bit length codes that announce an extended length
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  localparam logic [3:0] EXT_BYTES_16 = 4'd2;
  localparam logic [3:0] EXT_BYTES_64 = 4'd8;
  localparam logic [3:0] KEY_BYTES    = 4'd4;

  typedef enum logic [4:0] {
    PH_HDR0    = 5'b00001,
    PH_HDR1    = 5'b00010,
    PH_TAIL    = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_HALT    = 5'b10000
  } phase_e;

  typedef enum logic [2:0] {
    ERR_MASK   = 3'd0,
    ERR_LENGTH = 3'd1,
    ERR_CONT   = 3'd2,
    ERR_TEXT   = 3'd3,
    ERR_CLOSE  = 3'd4,
    ERR_RSVD   = 3'd5
  } err_code_e;

  // One classified word from the parser to the output stage
  typedef struct packed {
    logic      is_error;
    logic [7:0] data;
    logic [7:0] key;
    logic      last;
    err_code_e code;
  } entry_t;

endpackage
`default_nettype wire

// ===== rtl/wfr_parser.sv =====
// Header parser and payload classifier of the frame receiver.
// Depends on wfr_pkg and websocket_frame_receiver_top_defines.svh.
`default_nettype none
`include "websocket_frame_receiver_top_defines.svh"
module wfr_parser #(
  parameter int unsigned LenBits = 31
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i,
  input  logic            accept_i,
  input  logic [7:0]      byte_i,
  output logic            push_o,
  output wfr_pkg::entry_t entry_o
);
  import wfr_pkg::*;

  logic               role_q, role_d;
  phase_e             phase_q, phase_d;
  logic [3:0]         cnt_q, cnt_d;
  logic               final_q, final_d;
  logic [3:0]         opcode_q, opcode_d;
  logic [6:0]         len_code_q, len_code_d;
  logic [LenBits-1:0] acc_q, acc_d;
  logic               over_q, over_d;
  logic [31:0]        key_q, key_d;
  logic [LenBits-1:0] remain_q, remain_d;
  logic [1:0]         offset_q, offset_d;

  logic [6:0]         code_sel;
  logic [3:0]         ext_len;
  logic [3:0]         tail_len;
  logic [3:0]         cnt_inc;
  logic [LenBits+7:0] shifted;
  logic [1:0]         key_idx;
  logic [7:0]         key_byte;

  // The second header byte decides the length code in the same cycle
  assign code_sel = (phase_q == PH_HDR1) ? byte_i[6:0] : len_code_q;
  assign ext_len  = (code_sel == LEN_CODE_16) ? EXT_BYTES_16 :
                    (code_sel == LEN_CODE_64) ? EXT_BYTES_64 : 4'd0;
  assign tail_len = ext_len + (role_q ? KEY_BYTES : 4'd0);
  assign cnt_inc  = cnt_q + 4'd1;
  assign shifted  = {acc_q, byte_i};
  assign key_idx  = 2'd3 - offset_q;
  assign key_byte = key_q[{key_idx, 3'b000} +: 8];

  always_comb begin
    logic               do_check;
    logic               err_v;
    err_code_e          err_c;
    logic [LenBits-1:0] acc_v;
    logic               over_v;
    role_d     = cfg_we_i ? cfg_wdata_i : role_q;
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    final_d    = final_q;
    opcode_d   = opcode_q;
    len_code_d = len_code_q;
    acc_d      = acc_q;
    over_d     = over_q;
    key_d      = key_q;
    remain_d   = remain_q;
    offset_d   = offset_q;
    push_o     = 1'b0;
    entry_o    = '0;
    do_check   = 1'b0;
    err_v      = 1'b0;
    err_c      = ERR_MASK;
    acc_v      = acc_q;
    over_v     = over_q;

    if (accept_i) begin
      case (phase_q)
        PH_HDR0: begin
          final_d  = byte_i[7];
          opcode_d = byte_i[3:0];
          phase_d  = PH_HDR1;
        end
        PH_HDR1: begin
          if (byte_i[7] != role_q) begin
            err_v = 1'b1;
            err_c = ERR_MASK;
          end else begin
            len_code_d = byte_i[6:0];
            acc_v      = (byte_i[6:0] < LEN_CODE_16) ? LenBits'(byte_i[6:0]) : '0;
            over_v     = 1'b0;
            acc_d      = acc_v;
            over_d     = 1'b0;
            key_d      = '0;
            cnt_d      = '0;
            if (tail_len == 4'd0) begin
              do_check = 1'b1;
            end else begin
              phase_d = PH_TAIL;
            end
          end
        end
        PH_TAIL: begin
          if (cnt_q < ext_len) begin
            // Collect bits pushed past the limit into the overflow flag
            acc_v  = shifted[LenBits-1:0];
            over_v = over_q | (|shifted[LenBits+7:LenBits]);
            acc_d  = acc_v;
            over_d = over_v;
          end else begin
            key_d = {key_q[23:0], byte_i};
          end
          cnt_d = cnt_inc;
          if (cnt_inc >= tail_len) do_check = 1'b1;
        end
        PH_PAYLOAD: begin
          if (remain_q == '0) begin
            phase_d = PH_HDR0;
          end else begin
            if (opcode_q == OP_BINARY) begin
              push_o        = 1'b1;
              entry_o.data  = byte_i;
              entry_o.key   = key_byte;
              entry_o.last  = (remain_q == LenBits'(1));
            end
            remain_d = remain_q - LenBits'(1);
            offset_d = offset_q + 2'd1;
            if (remain_q == LenBits'(1)) phase_d = PH_HDR0;
          end
        end
        PH_HALT: begin
        end
        default: begin
        end
      endcase
    end

    // Header complete: length first, then opcode
    if (do_check) begin
      if (over_v) begin
        err_v = 1'b1;
        err_c = ERR_LENGTH;
      end else begin
        case (opcode_q)
          OP_CONT: begin
            err_v = 1'b1;
            err_c = ERR_CONT;
          end
          OP_TEXT: begin
            err_v = 1'b1;
            err_c = ERR_TEXT;
          end
          OP_BINARY: begin
            if (!final_q) begin
              err_v = 1'b1;
              err_c = ERR_CONT;
            end
          end
          OP_SHUTDOWN: begin
            err_v = 1'b1;
            err_c = ERR_CLOSE;
          end
          OP_PING, OP_PONG: begin
          end
          default: begin
            err_v = 1'b1;
            err_c = ERR_RSVD;
          end
        endcase
      end
      if (!err_v) begin
        remain_d = acc_v;
        offset_d = '0;
        phase_d  = (acc_v != '0) ? PH_PAYLOAD : PH_HDR0;
      end
    end

    if (err_v) begin
      push_o           = 1'b1;
      entry_o          = '0;
      entry_o.is_error = 1'b1;
      entry_o.code     = err_c;
      phase_d          = PH_HALT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      role_q     <= 1'b0;
      phase_q    <= PH_HDR0;
      cnt_q      <= '0;
      final_q    <= 1'b0;
      opcode_q   <= '0;
      len_code_q <= '0;
      acc_q      <= '0;
      over_q     <= 1'b0;
      key_q      <= '0;
      remain_q   <= '0;
      offset_q   <= '0;
    end else begin
      role_q     <= role_d;
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      final_q    <= final_d;
      opcode_q   <= opcode_d;
      len_code_q <= len_code_d;
      acc_q      <= acc_d;
      over_q     <= over_d;
      key_q      <= key_d;
      remain_q   <= remain_d;
      offset_q   <= offset_d;
    end
  end

  `WFR_ASSERT(a_halt_silent, clk_i, rst_ni, (phase_q == PH_HALT) |-> !push_o)
  `WFR_ASSERT(a_error_halts, clk_i, rst_ni, (push_o && entry_o.is_error) |=> (phase_q == PH_HALT))
  `WFR_ASSERT(a_payload_nonempty, clk_i, rst_ni, (phase_q == PH_PAYLOAD) |-> (remain_q != '0))
  `WFR_ASSERT(a_last_on_final, clk_i, rst_ni, (push_o && entry_o.last) |=> (phase_q == PH_HDR0))

endmodule
`default_nettype wire

// ===== rtl/wfr_queue.sv =====
// Small word queue between the parser and the output stage.
// Depends on wfr_pkg.
`default_nettype none
module wfr_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  wfr_pkg::entry_t entry_i,
  output logic            not_full_o,
  output logic            not_empty_o,
  input  logic            pop_i,
  output wfr_pkg::entry_t entry_o
);
  import wfr_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign not_full_o  = (count_q != CntW'(Depth));
  assign not_empty_o = (count_q != '0);
  assign do_push     = push_i && not_full_o;
  assign do_pop      = pop_i && not_empty_o;
  assign entry_o     = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/wfr_unmask.sv =====
// Output stage: unmask queued payload words and hold the result register.
// Depends on wfr_pkg.
`default_nettype none
module wfr_unmask (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            avail_i,
  input  wfr_pkg::entry_t entry_i,
  output logic            pop_o,
  output logic            valid_o,
  input  logic            ready_i,
  output logic            kind_o,
  output logic [7:0]      byte_o,
  output logic            last_o,
  output logic [2:0]      code_o
);
  import wfr_pkg::*;

  logic       valid_q, valid_d;
  logic       kind_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic [2:0] code_q;

  // Refill the result register whenever it is empty or being taken
  assign pop_o = avail_i && (!valid_q || ready_i);

  always_comb begin
    valid_d = valid_q;
    if (pop_o) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q <= entry_i.is_error;
      byte_q <= entry_i.data ^ entry_i.key;
      last_q <= entry_i.last;
      code_q <= entry_i.code;
    end
  end

  assign valid_o = valid_q;
  assign kind_o  = kind_q;
  assign byte_o  = byte_q;
  assign last_o  = last_q;
  assign code_o  = code_q;

endmodule
`default_nettype wire

// ===== rtl/websocket_frame_receiver_top.sv =====
// Top level of the WebSocket frame receiver: parser, queue, output stage.
// Depends on wfr_pkg, wfr_parser, wfr_queue and wfr_unmask.
//
//  port group   dir  width  contents
//  s_axis_*     in   8      received link bytes, one word per beat
//  m_axis_*     out  16     payload bytes of final binary frames, or one error
//  cfg_*        in   1      server role register, write only
//
// Flow: one byte is taken every clock while the queue has room; the parser
// decides a byte in the cycle it is accepted, its result word is written into the
// queue, and from the queue head it is registered in the output stage for m_axis.
// The result queue (QUEUE_DEPTH words) lets the parser run on while the
// output stalls; s_axis_tready_o drops only when the queue is full.
// Reset clears all control state: the parser waits for a first header byte.
// After an error the block drops every further byte until reset.
`default_nettype none
module websocket_frame_receiver_top #(
  parameter int unsigned PAYLOAD_LENGTH_BITS = wfr_pkg::PayloadLengthBitsDef,
  parameter int unsigned QUEUE_DEPTH         = wfr_pkg::QueueDepthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             cfg_we_i,
  input  logic                             cfg_wdata_i,     // server_role
  // receive stream
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [7:0]                       s_axis_tdata_i,  // [7:0] rx_byte
  // result stream
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [7:0] payload_byte, [10:8] error_code, [15:11] zero
  output logic [wfr_pkg::TdataOutBits-1:0] m_axis_tdata_o,
  output logic                             m_axis_tlast_o,  // frame_last
  output logic                             m_axis_tuser_o   // event_kind
);
  import wfr_pkg::*;

  logic   accept;
  logic   push;
  entry_t push_entry;
  logic   q_not_full;
  logic   q_not_empty;
  logic   pop;
  entry_t head_entry;
  logic [7:0] out_byte;
  logic [2:0] out_code;

  // Take a byte whenever the queue has room for the word it may produce
  assign s_axis_tready_o = q_not_full;
  assign accept          = s_axis_tvalid_i && q_not_full;

  wfr_parser #(
    .LenBits(PAYLOAD_LENGTH_BITS)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (accept),
    .byte_i     (s_axis_tdata_i),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  wfr_queue #(
    .Depth(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .entry_i    (push_entry),
    .not_full_o (q_not_full),
    .not_empty_o(q_not_empty),
    .pop_i      (pop),
    .entry_o    (head_entry)
  );

  wfr_unmask u_unmask (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .avail_i(q_not_empty),
    .entry_i(head_entry),
    .pop_o  (pop),
    .valid_o(m_axis_tvalid_o),
    .ready_i(m_axis_tready_i),
    .kind_o (m_axis_tuser_o),
    .byte_o (out_byte),
    .last_o (m_axis_tlast_o),
    .code_o (out_code)
  );

  // Pack the result word: payload byte low, error code above, zero fill
  assign m_axis_tdata_o = {(TdataOutBits - 11)'(0), out_code, out_byte};

endmodule
`default_nettype wire

// ===== bench/tb_websocket_frame_receiver_top.sv =====
// Self-checking testbench of websocket_frame_receiver_top.
// Depends on wfr_pkg and the receiver RTL; a built-in deframer model predicts every result word.
module tb_websocket_frame_receiver_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wfr_pkg::*;

  // Encodings of the payload length in the second header byte and after it
  localparam int LEN_FORM_7  = 0;
  localparam int LEN_FORM_16 = 1;
  localparam int LEN_FORM_64 = 2;

  localparam logic [63:0] LenMax       = (64'd1 << PayloadLengthBitsDef) - 64'd1;
  localparam int unsigned DrainCycles  = 8;    // parser, queue and output stage, with margin
  localparam int unsigned RandomItems  = 350;
  localparam int unsigned QuietItems   = 80;   // closing stretch without idling
  localparam int unsigned DrainTimeout = 5000;

  typedef struct {
    logic       kind;
    logic [7:0] data;
    logic       last;
    logic [2:0] code;
  } rx_event_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;    // [7:0] rx_byte
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [15:0] m_axis_tdata_o;    // [7:0] payload_byte, [10:8] error_code, [15:11] zero
  logic        m_axis_tlast_o;    // frame_last
  logic        m_axis_tuser_o;    // event_kind

  // Deframer model state, reset values
  logic                            server_role_q = 1'b0;
  phase_e                          rx_phase      = PH_HDR0;
  logic [3:0]                      tail_count    = '0;
  logic                            hdr_final     = 1'b0;
  logic [3:0]                      hdr_opcode    = '0;
  logic [6:0]                      hdr_len_code  = '0;
  logic [63:0]                     len_acc       = '0;
  logic [31:0]                     key_word      = '0;
  logic [PayloadLengthBitsDef-1:0] bytes_left    = '0;
  logic [1:0]                      key_offset    = '0;
  logic                            halted        = 1'b0;

  rx_event_t   expected_events[$];
  int unsigned bytes_sent     = 0;
  int unsigned fail_count     = 0;
  logic        source_idle_en = 1'b0;
  logic        sink_stall_en  = 1'b0;

  websocket_frame_receiver_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),   // [7:0] rx_byte
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),   // [7:0] payload_byte, [10:8] error_code
    .m_axis_tlast_o  (m_axis_tlast_o),   // frame_last
    .m_axis_tuser_o  (m_axis_tuser_o)    // event_kind
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #5_000_000;
    $display("websocket_frame_receiver_top: mismatch");
    $finish;
  end

  task automatic report_error(input string what, input logic [63:0] got,
                              input logic [63:0] want);
    $display("ERROR: %s got 0x%0h want 0x%0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Deframer model
  // ---------------------------------------------------------------------------

  // Extended length bytes announced by the seven-bit length code
  function automatic logic [3:0] ext_bytes();
    case (hdr_len_code)
      LEN_CODE_16: return EXT_BYTES_16;
      LEN_CODE_64: return EXT_BYTES_64;
      default:     return 4'd0;
    endcase
  endfunction

  // Header tail size; the role is read live, so a role write mid-header counts
  function automatic logic [3:0] tail_bytes();
    return ext_bytes() + (server_role_q ? KEY_BYTES : 4'd0);
  endfunction

  // Latch the error and halt until reset
  task automatic push_error(input err_code_e code);
    halted   = 1'b1;
    rx_phase = PH_HALT;
    expected_events.push_back('{kind: 1'b1, data: 8'h00, last: 1'b0, code: code});
  endtask

  // Last header byte: length check first, then the opcode
  task automatic close_header();
    if (len_acc > LenMax) begin
      push_error(ERR_LENGTH);
    end else begin
      case (hdr_opcode)
        OP_CONT:     push_error(ERR_CONT);
        OP_TEXT:     push_error(ERR_TEXT);
        OP_BINARY:   if (!hdr_final) push_error(ERR_CONT);
        OP_SHUTDOWN: push_error(ERR_CLOSE);
        OP_PING, OP_PONG: ;
        default:     push_error(ERR_RSVD);
      endcase
    end
    if (!halted) begin
      bytes_left = len_acc[PayloadLengthBitsDef-1:0];
      key_offset = 2'd0;
      rx_phase   = (bytes_left != 0) ? PH_PAYLOAD : PH_HDR0;
    end
  endtask

  // Advance the model by one accepted byte and queue any result it causes
  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0] key_byte;
    if (halted) return;
    case (rx_phase)
      PH_HDR0: begin
        hdr_final  = b[7];
        hdr_opcode = b[3:0];
        rx_phase   = PH_HDR1;
      end
      PH_HDR1: begin
        if (b[7] != server_role_q) begin
          push_error(ERR_MASK);
        end else begin
          hdr_len_code = b[6:0];
          len_acc      = (hdr_len_code < LEN_CODE_16) ? 64'(hdr_len_code) : 64'd0;
          key_word     = '0;
          tail_count   = '0;
          if (tail_bytes() == 0) close_header();
          else rx_phase = PH_TAIL;
        end
      end
      PH_TAIL: begin
        if (tail_count < ext_bytes()) len_acc = {len_acc[55:0], b};
        else key_word = {key_word[23:0], b};
        tail_count = tail_count + 4'd1;
        if (tail_count >= tail_bytes()) close_header();
      end
      PH_PAYLOAD: begin
        // Key byte by offset mod 4, first key byte in the top bits
        if (hdr_opcode == OP_BINARY) begin
          key_byte = key_word[24 - 8 * key_offset +: 8];
          expected_events.push_back('{kind: 1'b0, data: b ^ key_byte,
                                      last: (bytes_left == 1), code: 3'd0});
        end
        bytes_left = bytes_left - 1'b1;
        key_offset = key_offset + 2'd1;
        if (bytes_left == 0) rx_phase = PH_HDR0;
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one byte; optionally idle first, then hold it until accepted
  task automatic send_byte(input logic [7:0] b);
    if (source_idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    deframe_byte(b);
    bytes_sent++;
  endtask

  // Drop valid, wait for every queued result, then let the pipeline settle
  task automatic wait_idle();
    int unsigned waited;
    s_axis_tvalid_i <= 1'b0;
    waited = 0;
    while (expected_events.size() != 0 && waited < DrainTimeout) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_events.size() != 0) begin
      report_error("results left undelivered", expected_events.size(), 0);
      expected_events.delete();
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write the role register; call only while the block is idle
  task automatic write_role(input logic role);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= role;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    server_role_q  = role;
  endtask

  // Header bytes: first byte with random reserved bits, length, extended length, key
  task automatic send_header(input logic fin, input logic [3:0] op, input logic [63:0] len,
                             input int form, input logic mask);
    logic [2:0] rsv;
    logic [6:0] code;
    int         k;
    rsv  = $urandom_range(0, 7);
    code = (form == LEN_FORM_16) ? LEN_CODE_16 :
           (form == LEN_FORM_64) ? LEN_CODE_64 : len[6:0];
    send_byte({fin, rsv, op});
    send_byte({mask, code});
    if (form == LEN_FORM_16) begin
      send_byte(len[15:8]);
      send_byte(len[7:0]);
    end
    if (form == LEN_FORM_64) begin
      for (k = 7; k >= 0; k--) send_byte(len[8 * k +: 8]);
    end
    if (server_role_q) begin
      for (k = 0; k < 4; k++) send_byte(8'($urandom));
    end
  endtask

  // Whole frame in the current role; fill < 0 gives random payload bytes
  task automatic send_frame(input logic fin, input logic [3:0] op, input logic [63:0] len,
                            input int form, input int fill);
    logic [7:0] pb;
    send_header(fin, op, len, form, server_role_q);
    repeat (int'(len)) begin
      pb = (fill < 0) ? 8'($urandom) : 8'(fill);
      send_byte(pb);
    end
  endtask

  // Result side: random stall bursts while enabled, ready otherwise
  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (sink_stall_en && $urandom_range(0, 7) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
    end
  end

  // Compare each accepted result word with the oldest expected event
  always @(posedge clk_i) begin : check_events
    rx_event_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_events.size() == 0) begin
        report_error("result with none expected", m_axis_tdata_o, 0);
      end else begin
        want = expected_events.pop_front();
        if (m_axis_tuser_o !== want.kind)
          report_error("event_kind", m_axis_tuser_o, want.kind);
        if (m_axis_tdata_o[7:0] !== want.data)
          report_error("payload_byte", m_axis_tdata_o[7:0], want.data);
        if (m_axis_tlast_o !== want.last)
          report_error("frame_last", m_axis_tlast_o, want.last);
        if (m_axis_tdata_o[10:8] !== want.code)
          report_error("error_code", m_axis_tdata_o[10:8], want.code);
        if (m_axis_tdata_o[15:11] !== 5'd0)
          report_error("tdata padding", m_axis_tdata_o[15:11], 0);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Client role: unmasked frames, all length forms, payload extremes, empty frames
  task automatic test_unmasked_frames();
    wait_idle();
    write_role(1'b0);
    source_idle_en = 1'b1;
    sink_stall_en  = 1'b1;
    send_frame(1'b1, OP_BINARY, 1, LEN_FORM_7, 8'h00);
    send_frame(1'b1, OP_BINARY, 3, LEN_FORM_7, 8'hff);
    send_frame(1'b1, OP_PING, 2, LEN_FORM_7, -1);      // consumed silently
    send_frame(1'b1, OP_PONG, 0, LEN_FORM_7, -1);
    send_frame(1'b1, OP_BINARY, 0, LEN_FORM_7, -1);    // empty binary: no result
    send_frame(1'b1, OP_BINARY, 2, LEN_FORM_16, -1);
    send_frame(1'b1, OP_BINARY, 1, LEN_FORM_64, -1);
  endtask

  // Server role: masked frames, key wrap past four bytes
  task automatic test_masked_frames();
    wait_idle();
    write_role(1'b1);
    send_frame(1'b1, OP_BINARY, 5, LEN_FORM_7, -1);
    send_frame(1'b1, OP_PONG, 3, LEN_FORM_7, -1);
    send_frame(1'b1, OP_BINARY, 0, LEN_FORM_16, -1);
    send_frame(1'b1, OP_BINARY, 2, LEN_FORM_64, 8'h00);
  endtask

  // Flip the role inside a header tail; the tail size follows the live role
  task automatic test_role_change_mid_header();
    int k;
    // Client header with 16-bit length, then server role: key bytes follow
    wait_idle();
    write_role(1'b0);
    send_byte({1'b1, 3'd0, OP_BINARY});
    send_byte({1'b0, LEN_CODE_16});
    wait_idle();
    write_role(1'b1);
    send_byte(8'h00);
    send_byte(8'h03);
    for (k = 0; k < 4; k++) send_byte(8'($urandom));
    repeat (3) send_byte(8'($urandom));
    // Server header awaiting a key, then client role: one key byte ends the header
    wait_idle();
    send_byte({1'b1, 3'd0, OP_BINARY});
    send_byte({1'b1, 7'd4});
    wait_idle();
    write_role(1'b0);
    send_byte(8'($urandom));
    repeat (4) send_byte(8'($urandom));
  endtask

  // Well-formed frames with random content, lengths, roles and idling
  task automatic test_random_frames();
    int unsigned start;
    int unsigned pick;
    logic [3:0]  op;
    logic [63:0] len;
    int          form;
    start = bytes_sent;
    while (bytes_sent - start < RandomItems) begin
      if ($urandom_range(0, 9) == 0) begin
        wait_idle();
        write_role(~server_role_q);
      end
      // No idling at all in the closing stretch
      if (bytes_sent - start + QuietItems >= RandomItems) begin
        source_idle_en = 1'b0;
        sink_stall_en  = 1'b0;
      end else begin
        source_idle_en = ($urandom_range(0, 3) != 0);
        sink_stall_en  = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 9);
      op   = (pick < 7) ? OP_BINARY : (pick < 9) ? OP_PING : OP_PONG;
      pick = $urandom_range(0, 9);
      len  = (pick == 0) ? 64'd0 :
             (pick < 8)  ? 64'($urandom_range(1, 8)) :
             (pick == 8) ? 64'($urandom_range(9, 40)) : 64'($urandom_range(41, 140));
      if (len > 125) form = $urandom_range(LEN_FORM_16, LEN_FORM_64);
      else if ($urandom_range(0, 3) != 0) form = LEN_FORM_7;
      else form = $urandom_range(LEN_FORM_16, LEN_FORM_64);
      send_frame(1'b1, op, len, form, -1);
    end
  endtask

  // One protocol violation picked at random, or raw noise, then bytes that must be dropped
  task automatic test_sticky_error();
    int unsigned kind;
    int unsigned pick;
    logic [63:0] len;
    int          form;
    logic [3:0]  op;
    source_idle_en = 1'b0;
    sink_stall_en  = 1'b0;
    kind = $urandom_range(0, 6);
    len  = $urandom_range(0, 6);
    form = $urandom_range(LEN_FORM_7, LEN_FORM_64);
    case (kind)
      ERR_MASK:   send_header(1'b1, OP_BINARY, len, form, ~server_role_q);
      ERR_LENGTH: begin
        // Just over the limit, or far over it; any opcode, length is checked first
        len = LenMax + 64'd1;
        if ($urandom_range(0, 1) != 0) len = len + ({$urandom, $urandom} >> 1);
        send_header(1'b1, 4'($urandom), len, LEN_FORM_64, server_role_q);
      end
      ERR_CONT: begin
        if ($urandom_range(0, 1) != 0)
          send_header(1'($urandom), OP_CONT, len, form, server_role_q);
        else
          send_header(1'b0, OP_BINARY, len, form, server_role_q);
      end
      ERR_TEXT:   send_header(1'b1, OP_TEXT, len, form, server_role_q);
      ERR_CLOSE:  send_header(1'b1, OP_SHUTDOWN, len, form, server_role_q);
      ERR_RSVD: begin
        // Unassigned opcodes: 3..7 and B..F
        pick = $urandom_range(0, 9);
        op   = (pick < 5) ? 4'(4'd3 + pick) : 4'(4'hb + (pick - 5));
        send_header(1'b1, op, len, form, server_role_q);
      end
      default: repeat (40) send_byte(8'($urandom));
    endcase
    // Everything after the error is dropped, a good frame included
    send_frame(1'b1, OP_BINARY, 3, LEN_FORM_7, -1);
    repeat (16) send_byte(8'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= 8'h00;
    m_axis_tready_i <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_unmasked_frames();
    test_masked_frames();
    test_role_change_mid_header();
    test_random_frames();
    test_sticky_error();
    wait_idle();

    if (fail_count == 0) begin
      $display("websocket_frame_receiver_top: match");
    end else begin
      $display("websocket_frame_receiver_top: mismatch");
    end
    $finish;
  end

endmodule
